FILE: design/lcg_seeded_deck_shuffle_macros.svh
// Assertion macros used by the checker.
`ifndef LCG_SEEDED_DECK_SHUFFLE_MACROS_SVH
`define LCG_SEEDED_DECK_SHUFFLE_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define LCGDS_ASSERT_NOW(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("lcg_seeded_deck_shuffle: assertion failed");

// Next-cycle implication, disabled while reset is high.
`define LCGDS_ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("lcg_seeded_deck_shuffle: assertion failed");

`endif

FILE: design/lcgds_pkg.sv
package lcgds_pkg;

  // Widths fixed by the result fields and the generator.
  localparam int IDX_W  = 6;
  localparam int SPAN_W = 7;
  localparam int LCG_W  = 31;
  localparam int ROLL_W = 15;
  localparam int ROLL_LSB = 16;

  // Generator constants, taken modulo 2^31.
  localparam logic [LCG_W-1:0] LCG_MULT = 31'd214013;
  localparam logic [LCG_W-1:0] LCG_INCR = 31'd2531011;

  // Default deck size.
  localparam int DECK_SIZE_DEF = 52;

endpackage

FILE: design/lcgds_rem_unit.sv
module lcgds_rem_unit import lcgds_pkg::*; (
  input  logic              clk,
  input  logic              rst,
  input  logic              load,
  input  logic [ROLL_W-1:0] dividend,
  input  logic [SPAN_W-1:0] divisor,
  output logic              done,
  output logic [SPAN_W-1:0] remainder
);

  localparam int DVD_W = ROLL_W + (ROLL_W % 2);
  localparam int STEPS = DVD_W / 2;
  localparam int CNT_W = (STEPS > 1) ? $clog2(STEPS) : 1;

  logic [DVD_W-1:0]  dvd;
  logic [SPAN_W-1:0] dsr;
  logic [CNT_W-1:0]  cnt;
  logic              running;
  logic [SPAN_W-1:0] rem_mid;
  logic [SPAN_W-1:0] rem_next;

  // One restoring step: bring in the next dividend bit and subtract if it fits.
  // The partial remainder is always below the divisor, so its top bit is zero.
  function automatic logic [SPAN_W-1:0] rem_step(input logic [SPAN_W-1:0] r,
                                                 input logic b,
                                                 input logic [SPAN_W-1:0] d);
    logic [SPAN_W-1:0] t;
    t = {r[SPAN_W-2:0], b};
    rem_step = (t >= d) ? (t - d) : t;
  endfunction

  // Two bits of the dividend are retired each cycle while the unit is running.
  assign rem_mid  = rem_step(remainder, dvd[DVD_W-1], dsr);
  assign rem_next = rem_step(rem_mid, dvd[DVD_W-2], dsr);

  // Iteration control and the done pulse.
  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      cnt     <= '0;
    end else begin
      done <= 1'b0;
      if (load) begin
        running <= 1'b1;
        cnt     <= '0;
      end else if (running) begin
        cnt <= cnt + 1'b1;
        if (cnt == CNT_W'(STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // Dividend shifter, divisor and partial remainder.
  always_ff @(posedge clk) begin
    if (load) begin
      dvd       <= DVD_W'(dividend);
      dsr       <= divisor;
      remainder <= '0;
    end else if (running) begin
      dvd       <= {dvd[DVD_W-3:0], 2'b00};
      remainder <= rem_next;
    end
  end

endmodule

FILE: design/lcg_seeded_deck_shuffle.sv
// Seeded deck shuffle: a word on start with busy low carries deal_seed and
// begins a run. Busy stays high until the run has delivered its results.
// The run fills the order memory with the identity, then performs
// DECK_SIZE-1 swap steps, each made of the generator multiply, the remainder
// unit (two bits a cycle of a 16-bit dividend, then the state that sees done)
// and the single-port order memory (two reads, two writes). It then reads the
// order out in reverse, one entry a cycle.
// Results come out on valid, one word a cycle for DECK_SIZE words, with
// position ascending from zero, source_slot from the memory and last_card
// high on the final word. Each word is shown for exactly one cycle and the
// receiver cannot stall it. The next start is taken in the cycle that shows
// the last result.
// Synchronous reset returns the sequencer to idle, clears the generator
// state and drops valid; the order memory has no reset and is rewritten at
// the start of every run.
module lcg_seeded_deck_shuffle import lcgds_pkg::*; #(
  parameter int DECK_SIZE = DECK_SIZE_DEF
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             start,
  output logic             busy,
  input  logic [31:0]      deal_seed,
  output logic             valid,
  output logic [IDX_W-1:0] position,
  output logic [IDX_W-1:0] source_slot,
  output logic             last_card
);

  localparam int ADDR_W = (DECK_SIZE > 1) ? $clog2(DECK_SIZE) : 1;
  localparam logic [ADDR_W-1:0] LAST_IDX = ADDR_W'(DECK_SIZE - 1);
  localparam logic [ADDR_W-1:0] LAST_SWAP = ADDR_W'(DECK_SIZE - 2);

  typedef enum logic [8:0] {
    S_IDLE = 9'b0_0000_0001,
    S_FILL = 9'b0_0000_0010,
    S_MUL  = 9'b0_0000_0100,
    S_DIV  = 9'b0_0000_1000,
    S_RDI  = 9'b0_0001_0000,
    S_RDJ  = 9'b0_0010_0000,
    S_WRI  = 9'b0_0100_0000,
    S_WRJ  = 9'b0_1000_0000,
    S_OUT  = 9'b1_0000_0000
  } state_t;

  state_t            state;
  logic [ADDR_W-1:0] idx;
  logic [ADDR_W-1:0] jdx;
  logic [IDX_W-1:0]  hold;
  logic [LCG_W-1:0]  lcg_state;
  logic [LCG_W-1:0]  lcg_next;

  logic [IDX_W-1:0]  order_mem [DECK_SIZE];
  logic              mem_we;
  logic [ADDR_W-1:0] mem_addr;
  logic [IDX_W-1:0]  mem_wdata;
  logic [IDX_W-1:0]  mem_rdata;

  logic              div_load;
  logic              div_done;
  logic [SPAN_W-1:0] div_span;
  logic [SPAN_W-1:0] div_rem;

  assign busy = (state != S_IDLE);

  // Next generator state; the 31-bit context gives the modulo for free.
  assign lcg_next = lcg_state * LCG_MULT + LCG_INCR;

  // The remainder unit is loaded with the fresh roll in the multiply cycle.
  assign div_load = (state == S_MUL);
  assign div_span = SPAN_W'(DECK_SIZE) - SPAN_W'(idx);

  lcgds_rem_unit u_rem (
    .clk       (clk),
    .rst       (rst),
    .load      (div_load),
    .dividend  (lcg_next[ROLL_LSB +: ROLL_W]),
    .divisor   (div_span),
    .done      (div_done),
    .remainder (div_rem)
  );

  // Memory port selection for each sequencer state.
  always_comb begin
    mem_we    = 1'b0;
    mem_addr  = idx;
    mem_wdata = mem_rdata;
    case (state)
      S_FILL: begin
        mem_we    = 1'b1;
        mem_wdata = IDX_W'(idx);
      end
      S_RDJ: mem_addr = jdx;
      S_WRI: mem_we = 1'b1;
      S_WRJ: begin
        mem_we    = 1'b1;
        mem_addr  = jdx;
        mem_wdata = hold;
      end
      S_OUT: mem_addr = LAST_IDX - idx;
      default: ;
    endcase
  end

  // Order memory: one access a cycle, registered read data.
  always_ff @(posedge clk) begin
    if (mem_we) begin
      order_mem[mem_addr] <= mem_wdata;
    end
    mem_rdata <= order_mem[mem_addr];
  end

  assign source_slot = mem_rdata;

  // Sequencer: fill, swap steps, then read-out in reverse order.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      idx       <= '0;
      lcg_state <= '0;
      valid     <= 1'b0;
      last_card <= 1'b0;
    end else begin
      valid     <= 1'b0;
      last_card <= 1'b0;
      case (state)
        S_IDLE: begin
          if (start) begin
            lcg_state <= deal_seed[LCG_W-1:0];
            idx       <= '0;
            state     <= S_FILL;
          end
        end
        S_FILL: begin
          if (idx == LAST_IDX) begin
            idx   <= '0;
            state <= S_MUL;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        S_MUL: begin
          lcg_state <= lcg_next;
          state     <= S_DIV;
        end
        S_DIV: begin
          if (div_done) begin
            state <= S_RDI;
          end
        end
        S_RDI: state <= S_RDJ;
        S_RDJ: state <= S_WRI;
        S_WRI: state <= S_WRJ;
        S_WRJ: begin
          if (idx == LAST_SWAP) begin
            idx   <= '0;
            state <= S_OUT;
          end else begin
            idx   <= idx + 1'b1;
            state <= S_MUL;
          end
        end
        S_OUT: begin
          valid <= 1'b1;
          if (idx == LAST_IDX) begin
            last_card <= 1'b1;
            state     <= S_IDLE;
          end else begin
            idx <= idx + 1'b1;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Swap partner, the value read from slot i, and the result position.
  always_ff @(posedge clk) begin
    if (state == S_DIV && div_done) begin
      jdx <= LAST_IDX - ADDR_W'(div_rem);
    end
    if (state == S_RDJ) begin
      hold <= mem_rdata;
    end
    position <= IDX_W'(idx);
  end

endmodule

FILE: design/lcgds_checker.sv
`include "lcg_seeded_deck_shuffle_macros.svh"

module lcgds_checker import lcgds_pkg::*; #(
  parameter int DECK_SIZE = DECK_SIZE_DEF
) (
  input logic             clk,
  input logic             rst,
  input logic             start,
  input logic             busy,
  input logic             valid,
  input logic [IDX_W-1:0] position,
  input logic             last_card
);

  localparam logic [IDX_W-1:0] LAST_POS = IDX_W'(DECK_SIZE - 1);

  // An accepted seed makes the block busy once the sequencer leaves idle.
  `LCGDS_ASSERT_NEXT(a_start_busy, clk, rst, start && !busy, busy)

  // The final word of a run carries the last position.
  `LCGDS_ASSERT_NOW(a_last_pos, clk, rst, valid && last_card, position == LAST_POS)

  // Words of a run follow back to back with ascending positions.
  `LCGDS_ASSERT_NEXT(a_pos_step, clk, rst, valid && !last_card, valid && (position == $past(position) + 1'b1))

  // A flag without a strobe would be a word the receiver never sees.
  `LCGDS_ASSERT_NOW(a_last_valid, clk, rst, last_card, valid)

endmodule

bind lcg_seeded_deck_shuffle lcgds_checker #(
  .DECK_SIZE(DECK_SIZE)
) u_checker (
  .clk       (clk),
  .rst       (rst),
  .start     (start),
  .busy      (busy),
  .valid     (valid),
  .position  (position),
  .last_card (last_card)
);
